FILE: src/frustum_sphere_cull_assert.svh
`ifndef FRUSTUM_SPHERE_CULL_ASSERT_SVH
`define FRUSTUM_SPHERE_CULL_ASSERT_SVH

// same-cycle implication, checked outside reset
`define FSC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("frustum_sphere_cull: same-cycle check failed");

// next-cycle implication, checked outside reset
`define FSC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("frustum_sphere_cull: next-cycle check failed");

`endif

FILE: src/fsc_pkg.sv
package fsc_pkg;

	localparam int unsigned POS_W    = 20;
	localparam int unsigned RAD_W    = 19;
	localparam int unsigned COEF_W   = 16;
	localparam int unsigned PROD_W   = POS_W + COEF_W;   // 36
	localparam int unsigned VIEW_W   = PROD_W + 1;       // 37
	localparam int unsigned PLANE_W  = VIEW_W + COEF_W;  // 53
	localparam int unsigned DIST_W   = PLANE_W + 1;      // 54
	localparam int unsigned DEPTH_W  = VIEW_W + 1;       // 38
	localparam int unsigned FRAC_SH  = 14;
	localparam int unsigned ADDR_W   = 6;
	localparam int unsigned DATA_W   = 64;

	localparam logic [2:0] REG_ROW0    = 3'd0;
	localparam logic [2:0] REG_ROW1    = 3'd1;
	localparam logic [2:0] REG_ROW2    = 3'd2;
	localparam logic [2:0] REG_TRANS   = 3'd3;
	localparam logic [2:0] REG_NORMALS = 3'd4;
	localparam logic [2:0] REG_NEAR    = 3'd5;
	localparam logic [2:0] REG_FAR     = 3'd6;

	typedef logic signed [PROD_W-1:0]  prod_t;
	typedef logic signed [VIEW_W-1:0]  view_t;
	typedef logic signed [PLANE_W-1:0] plane_t;

endpackage

FILE: src/frustum_sphere_cull.sv
// throughput: one sphere per cycle while out_stall is low; stage 1 the matrix products, stage 2 the view sums,
// stage 3 the plane products and depth tests, stage 4 the side-plane sums and compares
// a stage is refilled whenever it is empty or its successor moves on
// reset clears all stage valid bits and every configuration register to zero
`include "frustum_sphere_cull_assert.svh"

module frustum_sphere_cull (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [fsc_pkg::ADDR_W-1:0]          paddr,
	input  logic [fsc_pkg::DATA_W-1:0]          pwdata,
	output logic [fsc_pkg::DATA_W-1:0]          prdata,
	output logic                                pready,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [fsc_pkg::POS_W-1:0]    center_x,
	input  logic signed [fsc_pkg::POS_W-1:0]    center_y,
	input  logic signed [fsc_pkg::POS_W-1:0]    center_z,
	input  logic [fsc_pkg::RAD_W-1:0]           radius,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                visible
);

	// configuration registers
	logic [47:0] row_q [3];
	logic [59:0] trans_q;
	logic [63:0] normals_q;
	logic signed [fsc_pkg::POS_W-1:0] near_q;
	logic signed [fsc_pkg::POS_W-1:0] far_q;

	logic [2:0] reg_idx;
	logic       cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = paddr[5:3];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q[0]  <= '0;
			row_q[1]  <= '0;
			row_q[2]  <= '0;
			trans_q   <= '0;
			normals_q <= '0;
			near_q    <= '0;
			far_q     <= '0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				fsc_pkg::REG_ROW0:    row_q[0]  <= pwdata[47:0];
				fsc_pkg::REG_ROW1:    row_q[1]  <= pwdata[47:0];
				fsc_pkg::REG_ROW2:    row_q[2]  <= pwdata[47:0];
				fsc_pkg::REG_TRANS:   trans_q   <= pwdata[59:0];
				fsc_pkg::REG_NORMALS: normals_q <= pwdata;
				fsc_pkg::REG_NEAR:    near_q    <= pwdata[19:0];
				fsc_pkg::REG_FAR:     far_q     <= pwdata[19:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			fsc_pkg::REG_ROW0:    prdata = 64'(row_q[0]);
			fsc_pkg::REG_ROW1:    prdata = 64'(row_q[1]);
			fsc_pkg::REG_ROW2:    prdata = 64'(row_q[2]);
			fsc_pkg::REG_TRANS:   prdata = 64'(trans_q);
			fsc_pkg::REG_NORMALS: prdata = normals_q;
			fsc_pkg::REG_NEAR:    prdata = 64'(near_q[fsc_pkg::POS_W-1:0]);
			fsc_pkg::REG_FAR:     prdata = 64'(far_q[fsc_pkg::POS_W-1:0]);
			default:              prdata = '0;
		endcase
	end

	// plane normal entries
	logic signed [fsc_pkg::COEF_W-1:0] hx, hz, vy, vz;
	assign hx = $signed(normals_q[15:0]);
	assign hz = $signed(normals_q[31:16]);
	assign vy = $signed(normals_q[47:32]);
	assign vz = $signed(normals_q[63:48]);

	// pipeline flow control
	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	assign rdy4     = !v_s4 || !out_stall;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_stall = !rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	// stage 1: nine matrix products, m_s1[i][j] = p_i * R_i[j]
	fsc_pkg::prod_t m_s1 [3][3];
	logic [fsc_pkg::RAD_W-1:0] r_s1;
	fsc_pkg::prod_t m_d [3][3];
	logic signed [fsc_pkg::POS_W-1:0] p_in [3];

	assign p_in[0] = center_x;
	assign p_in[1] = center_y;
	assign p_in[2] = center_z;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				m_d[i][j] = fsc_pkg::PROD_W'(p_in[i])
					* fsc_pkg::PROD_W'($signed(row_q[i][16*j +: 16]));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			m_s1 <= m_d;
			r_s1 <= radius;
		end
	end

	// stage 2: view-space coordinates, 22 fraction bits
	fsc_pkg::view_t view_s2 [3];
	logic [fsc_pkg::RAD_W-1:0] r_s2;
	fsc_pkg::view_t view_d [3];

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			view_d[j] = fsc_pkg::VIEW_W'(m_s1[0][j]) + fsc_pkg::VIEW_W'(m_s1[1][j])
				+ fsc_pkg::VIEW_W'(m_s1[2][j])
				+ fsc_pkg::VIEW_W'($signed({trans_q[20*j +: 20], 14'd0}));
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			view_s2 <= view_d;
			r_s2    <= r_s1;
		end
	end

	// stage 3: plane products and depth tests
	fsc_pkg::plane_t pa_s3, pb_s3, pc_s3, pd_s3;
	logic [fsc_pkg::RAD_W-1:0] r_s3;
	logic cull_s3;

	logic signed [fsc_pkg::DEPTH_W-1:0] z_ext, r22, near22, far22;
	logic cull_d;

	always_comb begin
		z_ext  = fsc_pkg::DEPTH_W'(view_s2[2]);
		r22    = fsc_pkg::DEPTH_W'($signed({1'b0, r_s2, 14'd0}));
		near22 = fsc_pkg::DEPTH_W'($signed({near_q, 14'd0}));
		far22  = fsc_pkg::DEPTH_W'($signed({far_q, 14'd0}));
		cull_d = (z_ext + r22 <= near22) || (z_ext - r22 >= far22);
	end

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			pa_s3   <= fsc_pkg::PLANE_W'(hx) * fsc_pkg::PLANE_W'(view_s2[0]);
			pb_s3   <= fsc_pkg::PLANE_W'(hz) * fsc_pkg::PLANE_W'(view_s2[2]);
			pc_s3   <= fsc_pkg::PLANE_W'(vy) * fsc_pkg::PLANE_W'(view_s2[1]);
			pd_s3   <= fsc_pkg::PLANE_W'(vz) * fsc_pkg::PLANE_W'(view_s2[2]);
			r_s3    <= r_s2;
			cull_s3 <= cull_d;
		end
	end

	// stage 4: side-plane distances, 36 fraction bits, against -r
	logic signed [fsc_pkg::DIST_W:0] pdist [4];
	logic signed [fsc_pkg::DIST_W:0] neg_r36;
	logic side_cull;
	logic visible_s4;

	always_comb begin
		pdist[0] = (fsc_pkg::DIST_W+1)'(pa_s3) + (fsc_pkg::DIST_W+1)'(pb_s3);
		pdist[1] = (fsc_pkg::DIST_W+1)'(pb_s3) - (fsc_pkg::DIST_W+1)'(pa_s3);
		pdist[2] = (fsc_pkg::DIST_W+1)'(pd_s3) - (fsc_pkg::DIST_W+1)'(pc_s3);
		pdist[3] = (fsc_pkg::DIST_W+1)'(pd_s3) + (fsc_pkg::DIST_W+1)'(pc_s3);
		neg_r36 = -(fsc_pkg::DIST_W+1)'($signed({1'b0, r_s3, 28'd0}));
		side_cull = 1'b0;
		for (int k = 0; k < 4; k++) begin
			if (pdist[k] <= neg_r36) side_cull = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy4 && v_s3) begin
			visible_s4 <= !(cull_s3 || side_cull);
		end
	end

	assign out_valid = v_s4;
	assign visible   = visible_s4;

	`FSC_ASSERT_NOW(a_stall_only_when_full, in_stall, v_s1 && v_s2 && v_s3 && v_s4)
	`FSC_ASSERT_NEXT(a_accept_fills_s1, in_valid && !in_stall, v_s1)
	`FSC_ASSERT_NEXT(a_s3_holds, v_s3 && !rdy4, v_s3 && $stable(cull_s3) && $stable(pa_s3))
	`FSC_ASSERT_NEXT(a_s4_drains, v_s4 && !out_stall && !v_s3, !v_s4)

endmodule
